>>> design/tfcm_pkg.sv
package tfcm_pkg;

	localparam int TFCM_RAW_BITS     = 16;
	localparam int TFCM_SRC_ENTRIES  = 128;
	localparam int TFCM_SRC_IDX_BITS = $clog2(TFCM_SRC_ENTRIES);
	localparam int TFCM_LEVEL_BITS   = 8;
	localparam int TFCM_GAIN_BITS    = 24;
	localparam int TFCM_CFG_BITS     = 24;

	localparam logic [15:0] TFCM_DRIFT_RESET = 16'd0;
	localparam logic [15:0] TFCM_LOW_RESET   = 16'd7404;
	localparam logic [23:0] TFCM_GAIN_RESET  = 24'd83558;

	typedef enum logic [1:0] {
		REG_DRIFT_OFFSET,
		REG_LOW_COUNT,
		REG_SPAN_GAIN,
		REG_COLOR_MODE
	} tfcm_reg_t;

	typedef enum logic {
		MODE_IRON,
		MODE_GRAY
	} tfcm_mode_t;

	typedef struct packed {
		logic signed [15:0] drift_offset;
		logic [15:0]        low_count;
		logic [23:0]        span_gain;
		tfcm_mode_t         color_mode;
	} tfcm_cfg_t;

	typedef struct packed {
		logic                       valid;
		logic [TFCM_LEVEL_BITS-1:0] level;
	} tfcm_level_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} tfcm_rgb_t;

	localparam logic [7:0] IRON_RED [TFCM_SRC_ENTRIES] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd2, 8'd4,
		8'd7, 8'd11, 8'd14, 8'd20, 8'd27, 8'd33, 8'd41, 8'd48,
		8'd55, 8'd61, 8'd66, 8'd72, 8'd78, 8'd84, 8'd91, 8'd97,
		8'd104, 8'd110, 8'd115, 8'd122, 8'd128, 8'd134, 8'd139, 8'd146,
		8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd175, 8'd178, 8'd182,
		8'd185, 8'd188, 8'd191, 8'd193, 8'd195, 8'd198, 8'd201, 8'd203,
		8'd206, 8'd208, 8'd210, 8'd212, 8'd214, 8'd217, 8'd219, 8'd221,
		8'd223, 8'd224, 8'd226, 8'd228, 8'd229, 8'd231, 8'd232, 8'd234,
		8'd235, 8'd236, 8'd237, 8'd238, 8'd239, 8'd240, 8'd241, 8'd241,
		8'd242, 8'd243, 8'd244, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248,
		8'd248, 8'd249, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
		8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};

	localparam logic [7:0] IRON_GREEN [TFCM_SRC_ENTRIES] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd2,
		8'd4, 8'd5, 8'd6, 8'd8, 8'd11, 8'd13, 8'd17, 8'd20,
		8'd23, 8'd26, 8'd29, 8'd33, 8'd37, 8'd41, 8'd46, 8'd49,
		8'd53, 8'd56, 8'd60, 8'd64, 8'd68, 8'd72, 8'd76, 8'd78,
		8'd82, 8'd86, 8'd90, 8'd93, 8'd96, 8'd100, 8'd103, 8'd106,
		8'd109, 8'd113, 8'd116, 8'd120, 8'd125, 8'd129, 8'd133, 8'd136,
		8'd139, 8'd142, 8'd145, 8'd149, 8'd154, 8'd159, 8'd163, 8'd168,
		8'd172, 8'd176, 8'd179, 8'd184, 8'd187, 8'd191, 8'd195, 8'd199,
		8'd202, 8'd205, 8'd208, 8'd212, 8'd216, 8'd219, 8'd221, 8'd224,
		8'd227, 8'd229, 8'd232, 8'd235, 8'd238, 8'd239, 8'd241, 8'd242,
		8'd244, 8'd245, 8'd247, 8'd248, 8'd249, 8'd251, 8'd253, 8'd254,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
	};

	localparam logic [7:0] IRON_BLUE [TFCM_SRC_ENTRIES] = '{
		8'd0, 8'd0, 8'd36, 8'd51, 8'd66, 8'd81, 8'd90, 8'd99,
		8'd106, 8'd115, 8'd119, 8'd123, 8'd128, 8'd133, 8'd137, 8'd140,
		8'd143, 8'd146, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd155,
		8'd155, 8'd156, 8'd157, 8'd157, 8'd157, 8'd157, 8'd157, 8'd156,
		8'd155, 8'd155, 8'd155, 8'd154, 8'd153, 8'd152, 8'd151, 8'd149,
		8'd149, 8'd147, 8'd146, 8'd144, 8'd142, 8'd139, 8'd135, 8'd132,
		8'd127, 8'd121, 8'd116, 8'd111, 8'd103, 8'd97, 8'd89, 8'd78,
		8'd66, 8'd54, 8'd42, 8'd30, 8'd25, 8'd20, 8'd16, 8'd12,
		8'd10, 8'd8, 8'd7, 8'd5, 8'd4, 8'd3, 8'd3, 8'd2,
		8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd1, 8'd2, 8'd5, 8'd9, 8'd12, 8'd15, 8'd23, 8'd32,
		8'd39, 8'd50, 8'd63, 8'd75, 8'd88, 8'd102, 8'd116, 8'd134,
		8'd149, 8'd164, 8'd179, 8'd192, 8'd203, 8'd216, 8'd228, 8'd239,
		8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd249, 8'd249
	};

	function automatic tfcm_rgb_t iron_entry(input logic [TFCM_SRC_IDX_BITS-1:0] idx);
		tfcm_rgb_t c;
		c.r = IRON_RED[idx];
		c.g = IRON_GREEN[idx];
		c.b = IRON_BLUE[idx];
		return c;
	endfunction

	function automatic logic [7:0] widen_mix(input logic [7:0] nb, input logic [7:0] cur);
		logic [9:0] sum;
		sum = 10'(nb) + 10'(cur) + 10'({cur, 1'b0}) + 10'd2;
		return sum[9:2];
	endfunction

endpackage

>>> design/thermal_false_color_mapper_core.sv
// Channel   Signals                                   Direction  Handshake
// request   start, busy, raw_count                    in         start && !busy
// result    done, red, green, blue                    out        done strobe, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         cfg_valid && cfg_ready
//
// One pixel per clock once busy is low; each request passes through six register
// stages before done strobes: saturate, subtract, multiply, round and clamp,
// palette read, and interpolate (or the level on all three channels in gray mode).
// busy is high during reset and for the first cycle after it, low afterwards.
// The result side has no backpressure; done marks each pixel for one cycle.
module thermal_false_color_mapper_core import tfcm_pkg::*; #(
	parameter int RAW_BITS = TFCM_RAW_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [RAW_BITS-1:0]      raw_count,
	output logic                     done,
	output logic [7:0]               red,
	output logic [7:0]               green,
	output logic [7:0]               blue,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [1:0]               cfg_index,
	input  logic [TFCM_CFG_BITS-1:0] cfg_data
);

	tfcm_cfg_t   cfg_q;
	tfcm_level_t level;
	logic        busy_q;

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drift_offset <= TFCM_DRIFT_RESET;
			cfg_q.low_count    <= TFCM_LOW_RESET;
			cfg_q.span_gain    <= TFCM_GAIN_RESET;
			cfg_q.color_mode   <= MODE_IRON;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tfcm_reg_t'(cfg_index))
				REG_DRIFT_OFFSET: cfg_q.drift_offset <= cfg_data[15:0];
				REG_LOW_COUNT:    cfg_q.low_count    <= cfg_data[15:0];
				REG_SPAN_GAIN:    cfg_q.span_gain    <= cfg_data[23:0];
				REG_COLOR_MODE:   cfg_q.color_mode   <= tfcm_mode_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	tfcm_level #(
		.RAW_BITS (RAW_BITS)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy_q),
		.raw_count (raw_count),
		.cfg       (cfg_q),
		.level_out (level)
	);

	tfcm_palette u_palette (
		.clk        (clk),
		.arst_n     (arst_n),
		.level_in   (level),
		.color_mode (cfg_q.color_mode),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

endmodule

>>> design/tfcm_level.sv
module tfcm_level import tfcm_pkg::*; #(
	parameter int RAW_BITS = TFCM_RAW_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [RAW_BITS-1:0] raw_count,
	input  tfcm_cfg_t           cfg,
	output tfcm_level_t         level_out
);

	localparam int SW = ((RAW_BITS > 16) ? RAW_BITS : 16) + 2;
	localparam int PW = RAW_BITS + TFCM_GAIN_BITS;
	localparam logic [PW:0] ROUND_BIAS = (PW + 1)'(32768);

	logic signed [SW-1:0] sub;
	logic signed [SW-1:0] diff;
	logic [RAW_BITS-1:0]  sat;
	logic [PW:0]          rnd;
	logic [7:0]           lvl;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic [RAW_BITS-1:0]  sat_s1;
	logic [RAW_BITS-1:0]  diff_s2;
	logic [PW-1:0]        prod_s3;
	logic [7:0]           level_s4;

	always_comb begin
		sub = signed'(SW'(raw_count)) - SW'(cfg.drift_offset);
		if (sub[SW-1]) begin
			sat = '0;
		end else if (|sub[SW-2:RAW_BITS]) begin
			sat = '1;
		end else begin
			sat = sub[RAW_BITS-1:0];
		end
	end

	always_comb begin
		diff = signed'(SW'(sat_s1)) - signed'(SW'(cfg.low_count));
	end

	always_comb begin
		rnd = (PW + 1)'(prod_s3) + ROUND_BIAS;
		if (|rnd[PW:24]) begin
			lvl = 8'hFF;
		end else begin
			lvl = rnd[23:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		sat_s1 <= sat;
		if (diff[SW-1] || diff == '0) begin
			diff_s2 <= '0;
		end else begin
			diff_s2 <= diff[RAW_BITS-1:0];
		end
		prod_s3  <= PW'(diff_s2) * PW'(cfg.span_gain);
		level_s4 <= lvl;
	end

	assign level_out.valid = valid_s4;
	assign level_out.level = level_s4;

endmodule

>>> design/tfcm_palette.sv
module tfcm_palette import tfcm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tfcm_level_t level_in,
	input  tfcm_mode_t  color_mode,
	output logic        done,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue
);

	logic [TFCM_SRC_IDX_BITS-1:0] k;
	logic [TFCM_SRC_IDX_BITS-1:0] nb;

	logic       valid_s5, valid_s6;
	tfcm_rgb_t  cur_s5, nb_s5;
	logic [7:0] level_s5;
	tfcm_rgb_t  rgb_s6;

	always_comb begin
		k = level_in.level[TFCM_LEVEL_BITS-1:1];
		if (level_in.level[0]) begin
			nb = (k == '1) ? k : k + 1'b1;
		end else begin
			nb = (k == '0) ? k : k - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= level_in.valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		cur_s5   <= iron_entry(k);
		nb_s5    <= iron_entry(nb);
		level_s5 <= level_in.level;
		if (color_mode == MODE_GRAY) begin
			rgb_s6 <= '{r: level_s5, g: level_s5, b: level_s5};
		end else begin
			rgb_s6.r <= widen_mix(nb_s5.r, cur_s5.r);
			rgb_s6.g <= widen_mix(nb_s5.g, cur_s5.g);
			rgb_s6.b <= widen_mix(nb_s5.b, cur_s5.b);
		end
	end

	assign done  = valid_s6;
	assign red   = rgb_s6.r;
	assign green = rgb_s6.g;
	assign blue  = rgb_s6.b;

endmodule

>>> design/tfcm_checker.sv
module tfcm_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_req_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##6 done)
		else $error("request without result six cycles later");

	a_done_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result without a matching request");

	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");

endmodule

bind thermal_false_color_mapper_core tfcm_checker u_tfcm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
